### hw/rtl/wsa_pkg.sv
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types, codes and default sizes for the weighted scatter-accumulate
// unit: transaction payloads, operation codes and controller states.
// ----------------------------------------------------------------------------
package wsa_pkg;

	// Default sizes of the cell store.
	localparam int unsigned NUM_CELLS_DEF  = 1024;
	localparam int unsigned NUM_VARS_DEF   = 4;
	localparam int unsigned NUM_FIELDS_DEF = 4;

	// Fixed field widths of the transactions.
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned PROD_W   = VALUE_W + WEIGHT_W;

	// Operation codes; the spare code behaves as a read.
	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ACCUM = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_SPARE = 2'd3
	} func_t;

	// Input transaction.
	typedef struct packed {
		func_t                       func;
		logic [1:0]                  field_slot;
		logic [1:0]                  variable_index;
		logic [9:0]                  cell_index;
		logic signed [VALUE_W-1:0]   donor_value;
		logic [WEIGHT_W-1:0]         weight;
	} item_t;

	// Result transaction.
	typedef struct packed {
		logic signed [VALUE_W-1:0] cell_value;
		logic                      saturated;
	} result_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic read;
		logic update;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic result_free;
	} dp_status_t;

endpackage

### hw/rtl/weighted_scatter_accumulate_unit.sv
// ----------------------------------------------------------------------------
// weighted_scatter_accumulate_unit
// Receiver-cell accumulator memory: clears, accumulates weighted donor values
// into, and reads cells of a store addressed by field, variable and cell.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid, item_stall, item) carries one operation per
// transaction: clear, accumulate donor_value times weight, or read a cell.
// The result channel (result_valid, result_stall, result) returns exactly one
// transaction per item: the cell value after the operation and a flag that is
// set when an accumulate clipped the sum to the signed 32-bit range.
// Each item passes through capture, store read with the product formed, then
// the saturating update of the cell, which loads the result register. The
// controller handles one item at a time, so the next item is taken only after
// the previous one has completed its update.
// The next item is taken while a finished result still waits in the output
// register; when the receiver stalls, the following item stops before its
// update and holds until the output register frees up.
// Reset clears the control state only; the store holds no defined value until
// a cell is cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
module weighted_scatter_accumulate_unit #(
	parameter int unsigned NUM_CELLS  = wsa_pkg::NUM_CELLS_DEF,
	parameter int unsigned NUM_VARS   = wsa_pkg::NUM_VARS_DEF,
	parameter int unsigned NUM_FIELDS = wsa_pkg::NUM_FIELDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wsa_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wsa_pkg::result_t result
);

	wsa_pkg::ctrl_cmd_t  cmd;
	wsa_pkg::dp_status_t status;

	// Sequencing of one transaction at a time.
	wsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Address, arithmetic, cell store and result register.
	wsa_datapath #(
		.NUM_CELLS (NUM_CELLS),
		.NUM_VARS  (NUM_VARS),
		.NUM_FIELDS(NUM_FIELDS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

### hw/rtl/wsa_ram.sv
// ----------------------------------------------------------------------------
// wsa_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module wsa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/wsa_ctrl.sv
// ----------------------------------------------------------------------------
// wsa_ctrl
// Controller for the scatter-accumulate unit: takes one transaction at a time
// and steps it through store read and update.
// ----------------------------------------------------------------------------
module wsa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  wsa_pkg::dp_status_t status,
	output wsa_pkg::ctrl_cmd_t  cmd
);

	wsa_pkg::state_t state_q;
	wsa_pkg::state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			wsa_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_next = wsa_pkg::ST_READ;
				end
			end
			wsa_pkg::ST_READ: begin
				state_next = wsa_pkg::ST_UPDATE;
			end
			wsa_pkg::ST_UPDATE: begin
				if (status.result_free) begin
					state_next = wsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = wsa_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs: the update waits until the result register can take a value.
	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			wsa_pkg::ST_IDLE: begin
				item_stall  = 1'b0;
				cmd.capture = item_valid;
			end
			wsa_pkg::ST_READ: begin
				cmd.read = 1'b1;
			end
			wsa_pkg::ST_UPDATE: begin
				cmd.update = status.result_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

endmodule

### hw/rtl/wsa_datapath.sv
// ----------------------------------------------------------------------------
// wsa_datapath
// Datapath of the scatter-accumulate unit: address formation, weighted
// product, saturating read-modify-write of the cell store and result register.
// ----------------------------------------------------------------------------
module wsa_datapath #(
	parameter int unsigned NUM_CELLS  = wsa_pkg::NUM_CELLS_DEF,
	parameter int unsigned NUM_VARS   = wsa_pkg::NUM_VARS_DEF,
	parameter int unsigned NUM_FIELDS = wsa_pkg::NUM_FIELDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wsa_pkg::item_t      item,
	input  wsa_pkg::ctrl_cmd_t  cmd,
	output wsa_pkg::dp_status_t status,
	output logic                result_valid,
	input  logic                result_stall,
	output wsa_pkg::result_t    result
);

	localparam int unsigned DEPTH  = NUM_FIELDS * NUM_VARS * NUM_CELLS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned VW     = wsa_pkg::VALUE_W;
	localparam int unsigned PW     = wsa_pkg::PROD_W;
	localparam int unsigned SHW    = PW - wsa_pkg::FRAC_W;
	localparam int unsigned SUMW   = VW + 2;

	localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'(34'sh0_7FFF_FFFF);
	localparam logic signed [SUMW-1:0] SUM_MIN = -SUMW'(34'sh0_8000_0000);

	logic [ADDR_W-1:0]          addr;
	logic                       in_range;
	logic [ADDR_W-1:0]          addr_q;
	logic                       in_range_q;
	wsa_pkg::func_t             func_q;
	logic signed [VW-1:0]       donor_q;
	logic [wsa_pkg::WEIGHT_W-1:0] weight_q;
	logic signed [PW-1:0]       product_q;
	logic [VW-1:0]              rd_data;
	logic signed [SHW-1:0]      contrib;
	logic signed [SUMW-1:0]     sum;
	logic signed [VW-1:0]       acc_value;
	logic                       acc_sat;
	logic                       wr_en;
	logic [VW-1:0]              wr_data;
	wsa_pkg::result_t           result_next;
	logic                       result_valid_q;
	wsa_pkg::result_t           result_q;

	// Flat store address and range check of the incoming transaction.
	always_comb begin
		addr = (ADDR_W'(item.field_slot) * ADDR_W'(NUM_VARS) + ADDR_W'(item.variable_index))
			* ADDR_W'(NUM_CELLS) + ADDR_W'(item.cell_index);
		in_range = (32'(item.field_slot) < 32'(NUM_FIELDS))
			&& (32'(item.variable_index) < 32'(NUM_VARS))
			&& (32'(item.cell_index) < 32'(NUM_CELLS));
	end

	// Transaction registers, loaded when an item is taken.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q     <= addr;
			in_range_q <= in_range;
			func_q     <= item.func;
			donor_q    <= item.donor_value;
			weight_q   <= item.weight;
		end
	end

	// Weighted product, formed while the store is read.
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			product_q <= donor_q * $signed({1'b0, weight_q});
		end
	end

	// Arithmetic shift by the weight fraction and saturating add.
	always_comb begin
		contrib   = product_q[PW-1:wsa_pkg::FRAC_W];
		sum       = {{2{rd_data[VW-1]}}, rd_data} + {contrib[SHW-1], contrib};
		acc_sat   = 1'b0;
		acc_value = sum[VW-1:0];
		if (sum > SUM_MAX) begin
			acc_value = SUM_MAX[VW-1:0];
			acc_sat   = 1'b1;
		end else if (sum < SUM_MIN) begin
			acc_value = SUM_MIN[VW-1:0];
			acc_sat   = 1'b1;
		end
	end

	// Store write and result selection by operation.
	always_comb begin
		wr_en       = 1'b0;
		wr_data     = '0;
		result_next = '0;
		if (in_range_q) begin
			unique case (func_q)
				wsa_pkg::FUNC_CLEAR: begin
					wr_en = cmd.update;
				end
				wsa_pkg::FUNC_ACCUM: begin
					wr_en                 = cmd.update;
					wr_data               = acc_value;
					result_next.cell_value = acc_value;
					result_next.saturated  = acc_sat;
				end
				wsa_pkg::FUNC_READ, wsa_pkg::FUNC_SPARE: begin
					result_next.cell_value = rd_data;
				end
				default: begin
					result_next = '0;
				end
			endcase
		end
	end

	wsa_ram #(
		.WIDTH(VW),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_q),
		.wr_data(wr_data),
		.rd_en  (cmd.read),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// Result register: holds a finished transaction until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.update) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q <= result_next;
		end
	end

	assign status.result_free = !result_valid_q || !result_stall;
	assign result_valid       = result_valid_q;
	assign result             = result_q;

endmodule
